// ===== src/first_order_lag_implicit_euler_unit_macros.svh =====
// Assertion macros shared by the lag unit RTL.
// Included by files that check their own sequencing; no other dependencies.
`ifndef FIRST_ORDER_LAG_IMPLICIT_EULER_UNIT_MACROS_SVH
`define FIRST_ORDER_LAG_IMPLICIT_EULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FOLI_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FOLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/foli_pkg.sv =====
// Shared types and constants of the first-order lag unit.
// No dependencies; used by foli_core and the top level.
`timescale 1ns / 1ps

package foli_pkg;

    localparam int FRAC_BITS = 16;

    localparam int GAIN_RST          = 65536;
    localparam int TIME_CONSTANT_RST = 1000;
    localparam int MAX_STEP_RST      = 10000;
    localparam int INITIAL_VALUE_RST = 0;

    typedef enum logic [1:0] {
        CFG_GAIN,
        CFG_TIME_CONSTANT,
        CFG_MAX_STEP,
        CFG_INITIAL_VALUE
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

// ===== src/foli_core.sv =====
// Iterative lag update: one shared add/subtract unit under a sequencer does
// elapsed time, limit check, gain product, numerator accumulate and division.
// Depends on foli_pkg.
`timescale 1ns / 1ps

module foli_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     ack,
    input  logic [TIME_WIDTH-1:0]    timestamp,
    input  logic [TIME_WIDTH-1:0]    last_timestamp,
    input  logic [VALUE_WIDTH-1:0]   sample,
    input  logic [VALUE_WIDTH-1:0]   gain,
    input  logic [TIME_WIDTH-1:0]    time_constant,
    input  logic [TIME_WIDTH-1:0]    max_step,
    input  logic [VALUE_WIDTH-1:0]   held_output,
    output foli_pkg::core_stat_t     stat,
    output logic [VALUE_WIDTH-1:0]   result,
    output logic                     violation
);

    localparam int VW    = VALUE_WIDTH;
    localparam int TW    = TIME_WIDTH;
    localparam int NW    = VW + TW;
    localparam int ACC_W = VW + TW + 1;
    localparam int AW    = VW + TW + 2;
    localparam int MAXW  = (VW > TW) ? VW : TW;
    localparam int CNT_W = $clog2(MAXW);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DT,
        ST_CHK,
        ST_DSUM,
        ST_MAGK,
        ST_MAGX,
        ST_MUL,
        ST_SAT,
        ST_PREP,
        ST_MAC,
        ST_ABS,
        ST_DIV,
        ST_FIX,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TW-1:0]      ts_reg;
    logic [TW-1:0]      lts_reg;
    logic [VW-1:0]      x_reg;
    logic [TW-1:0]      dt_reg;
    logic [TW:0]        dsum_reg;
    logic [TW-1:0]      t1_sh_reg;
    logic [TW-1:0]      dt_sh_reg;
    logic [VW-1:0]      km_reg;
    logic [VW-1:0]      ph_reg;
    logic [VW-1:0]      ml_reg;
    logic [VW-1:0]      kpx_reg;
    logic [VW:0]        hk_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [TW:0]        rem_reg;
    logic [VW-1:0]      quo_reg;
    logic               rneg_reg;
    logic [VW-1:0]      result_reg;
    logic               viol_reg;

    logic [AW-1:0]      alu_a;
    logic [AW-1:0]      alu_b;
    logic               alu_sub;
    logic [AW-1:0]      alu_sum;
    logic               alu_neg;

    logic [TW-1:0]      t1_eff;
    logic               pneg;
    logic [2*VW-1:0]    prod_sh;
    logic               prod_over;
    logic [VW-1:0]      sat_limit;
    logic [VW-1:0]      gm;
    logic               cnt_last;

    assign t1_eff   = (time_constant == '0) ? TW'(1) : time_constant;
    assign pneg     = gain[VW-1] ^ x_reg[VW-1];
    assign cnt_last = (cnt_reg == '0);

    // saturate |gain*sample| >> FRAC_BITS to the signed range
    assign prod_sh   = {ph_reg, ml_reg} >> foli_pkg::FRAC_BITS;
    assign prod_over = (|prod_sh[2*VW-1:VW])
                     | (prod_sh[VW-1] & (~pneg | (|prod_sh[VW-2:0])));
    assign sat_limit = pneg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    assign gm        = prod_over ? sat_limit : prod_sh[VW-1:0];

    assign alu_sum = alu_a + (alu_b ^ {AW{alu_sub}}) + AW'(alu_sub);
    assign alu_neg = alu_sum[AW-1];

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_DT: begin
                alu_a   = AW'(ts_reg);
                alu_b   = AW'(lts_reg);
                alu_sub = 1'b1;
            end
            ST_CHK: begin
                alu_a   = AW'(max_step);
                alu_b   = AW'(dt_reg);
                alu_sub = 1'b1;
            end
            ST_DSUM: begin
                alu_a = AW'(t1_eff);
                alu_b = AW'(dt_reg);
            end
            ST_MAGK: begin
                alu_b   = AW'($signed(gain));
                alu_sub = gain[VW-1];
            end
            ST_MAGX: begin
                alu_b   = AW'($signed(x_reg));
                alu_sub = x_reg[VW-1];
            end
            ST_MUL: begin
                alu_a = AW'(ph_reg);
                alu_b = ml_reg[0] ? AW'(km_reg) : '0;
            end
            ST_SAT: begin
                alu_b   = AW'(gm);
                alu_sub = pneg;
            end
            ST_PREP: begin
                alu_a = AW'($signed(held_output));
                alu_b = AW'($signed(kpx_reg));
            end
            ST_MAC: begin
                alu_a = AW'($signed({acc_reg[ACC_W-2:0], 1'b0}));
                case ({t1_sh_reg[TW-1], dt_sh_reg[TW-1]})
                    2'b10:   alu_b = AW'($signed(held_output));
                    2'b01:   alu_b = AW'($signed(kpx_reg));
                    2'b11:   alu_b = AW'($signed(hk_reg));
                    default: alu_b = '0;
                endcase
            end
            ST_ABS: begin
                alu_b   = AW'($signed(acc_reg));
                alu_sub = acc_reg[ACC_W-1];
            end
            ST_DIV: begin
                alu_a   = AW'({rem_reg, quo_reg[VW-1]});
                alu_b   = AW'(dsum_reg);
                alu_sub = 1'b1;
            end
            ST_FIX: begin
                alu_b   = AW'(quo_reg);
                alu_sub = rneg_reg;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            viol_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        ts_reg    <= timestamp;
                        lts_reg   <= last_timestamp;
                        x_reg     <= sample;
                        state_reg <= ST_DT;
                    end
                end
                ST_DT: begin
                    dt_reg    <= alu_sum[TW-1:0];
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    viol_reg  <= alu_neg;
                    state_reg <= alu_neg ? ST_FINISH : ST_DSUM;
                end
                ST_DSUM: begin
                    dsum_reg  <= alu_sum[TW:0];
                    t1_sh_reg <= t1_eff;
                    dt_sh_reg <= dt_reg;
                    state_reg <= ST_MAGK;
                end
                ST_MAGK: begin
                    km_reg    <= alu_sum[VW-1:0];
                    state_reg <= ST_MAGX;
                end
                ST_MAGX: begin
                    ml_reg    <= alu_sum[VW-1:0];
                    ph_reg    <= '0;
                    cnt_reg   <= CNT_W'(VW - 1);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    ph_reg  <= alu_sum[VW:1];
                    ml_reg  <= {alu_sum[0], ml_reg[VW-1:1]};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_last) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    kpx_reg   <= alu_sum[VW-1:0];
                    state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    hk_reg    <= alu_sum[VW:0];
                    acc_reg   <= '0;
                    cnt_reg   <= CNT_W'(TW - 1);
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    acc_reg   <= alu_sum[ACC_W-1:0];
                    t1_sh_reg <= {t1_sh_reg[TW-2:0], 1'b0};
                    dt_sh_reg <= {dt_sh_reg[TW-2:0], 1'b0};
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    if (cnt_last) begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    rneg_reg  <= acc_reg[ACC_W-1];
                    rem_reg   <= {1'b0, alu_sum[NW-1:VW]};
                    quo_reg   <= alu_sum[VW-1:0];
                    cnt_reg   <= CNT_W'(VW - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (!alu_neg) begin
                        rem_reg <= alu_sum[TW:0];
                    end else begin
                        rem_reg <= {rem_reg[TW-1:0], quo_reg[VW-1]};
                    end
                    quo_reg <= {quo_reg[VW-2:0], ~alu_neg};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_last) begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    result_reg <= alu_sum[VW-1:0];
                    state_reg  <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (ack) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_FINISH);
    assign result    = result_reg;
    assign violation = viol_reg;

endmodule

// ===== src/first_order_lag_implicit_euler_unit.sv =====
// Top level of the first-order lag unit: APB register file, lag state,
// beat handshakes and output register. Depends on foli_pkg and foli_core.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   s_      | in        | s_valid / s_ready       | s_timestamp, s_sample, s_enable
//   m_      | out       | m_valid / m_ready       | m_lag_output, m_enabled_out,
//           |           |                         |   m_timing_violation
//   apb     | in        | psel, penable, pready   | paddr, pwdata, prdata
//
// A running beat's length is set by the bit-serial multiply, accumulate and
// divide passes of the shared adder in foli_core; a timing violation ends the
// beat after the limit check, and a beat that does not run leaves the core idle.
// s_ready drops from acceptance until the result moves into the output
// register; a stalled m_ready holds the finished result in foli_core.
// Reset is synchronous on aresetn low and restores registers and lag state.
`timescale 1ns / 1ps

`include "first_order_lag_implicit_euler_unit_macros.svh"

module first_order_lag_implicit_euler_unit #(
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 32,
    localparam int REG_W  = (VALUE_WIDTH > TIME_WIDTH) ? VALUE_WIDTH : TIME_WIDTH,
    localparam int BUS_W  = (REG_W > 32) ? 64 : 32,
    localparam int ADDR_W = (BUS_W > 32) ? 5 : 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [BUS_W-1:0]        pwdata,
    output logic [BUS_W-1:0]        prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [TIME_WIDTH-1:0]   s_timestamp,
    input  logic [VALUE_WIDTH-1:0]  s_sample,
    input  logic                    s_enable,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [VALUE_WIDTH-1:0]  m_lag_output,
    output logic                    m_enabled_out,
    output logic                    m_timing_violation
);

    localparam int VW = VALUE_WIDTH;
    localparam int TW = TIME_WIDTH;

    logic [VW-1:0]  gain_reg;
    logic [TW-1:0]  tc_reg;
    logic [TW-1:0]  ms_reg;
    logic [VW-1:0]  iv_reg;

    logic [TW-1:0]  last_ts_reg;
    logic [VW-1:0]  held_reg;
    logic           prev_en_reg;

    logic           busy_reg;
    logic           run_reg;
    logic           en_reg;

    logic           m_valid_reg;
    logic [VW-1:0]  m_lag_reg;
    logic           m_en_reg;
    logic           m_viol_reg;

    foli_pkg::cfg_idx_t   cfg_idx;
    foli_pkg::core_stat_t core_stat;
    logic                 cfg_wr;
    logic                 s_acc;
    logic                 core_start;
    logic                 core_ack;
    logic [VW-1:0]        core_result;
    logic                 core_viol;
    logic                 res_ready;
    logic                 load;
    logic [VW-1:0]        out_next;

    assign pready  = 1'b1;
    assign cfg_idx = foli_pkg::cfg_idx_t'(paddr[ADDR_W-1 -: 2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_idx)
            foli_pkg::CFG_GAIN:          prdata = BUS_W'(gain_reg);
            foli_pkg::CFG_TIME_CONSTANT: prdata = BUS_W'(tc_reg);
            foli_pkg::CFG_MAX_STEP:      prdata = BUS_W'(ms_reg);
            foli_pkg::CFG_INITIAL_VALUE: prdata = BUS_W'(iv_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= VW'(foli_pkg::GAIN_RST);
            tc_reg   <= TW'(foli_pkg::TIME_CONSTANT_RST);
            ms_reg   <= TW'(foli_pkg::MAX_STEP_RST);
            iv_reg   <= VW'(foli_pkg::INITIAL_VALUE_RST);
        end else if (cfg_wr) begin
            case (cfg_idx)
                foli_pkg::CFG_GAIN:          gain_reg <= pwdata[VW-1:0];
                foli_pkg::CFG_TIME_CONSTANT: tc_reg   <= pwdata[TW-1:0];
                foli_pkg::CFG_MAX_STEP:      ms_reg   <= pwdata[TW-1:0];
                foli_pkg::CFG_INITIAL_VALUE: iv_reg   <= pwdata[VW-1:0];
                default: begin
                    gain_reg <= gain_reg;
                end
            endcase
        end
    end

    assign s_ready    = ~busy_reg;
    assign s_acc      = s_valid & s_ready;
    assign core_start = s_acc & prev_en_reg & s_enable;

    assign res_ready = busy_reg & (~run_reg | core_stat.done);
    assign load      = res_ready & (~m_valid_reg | m_ready);
    assign core_ack  = load & run_reg;
    assign out_next  = ~run_reg ? iv_reg : (core_viol ? held_reg : core_result);

    foli_core #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (core_start),
        .ack            (core_ack),
        .timestamp      (s_timestamp),
        .last_timestamp (last_ts_reg),
        .sample         (s_sample),
        .gain           (gain_reg),
        .time_constant  (tc_reg),
        .max_step       (ms_reg),
        .held_output    (held_reg),
        .stat           (core_stat),
        .result         (core_result),
        .violation      (core_viol)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ts_reg <= '0;
            held_reg    <= '0;
            prev_en_reg <= 1'b0;
            busy_reg    <= 1'b0;
            run_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                busy_reg    <= 1'b1;
                run_reg     <= prev_en_reg & s_enable;
                en_reg      <= s_enable;
                last_ts_reg <= s_timestamp;
                prev_en_reg <= s_enable;
            end
            if (load) begin
                busy_reg    <= 1'b0;
                held_reg    <= out_next;
                m_valid_reg <= 1'b1;
                m_lag_reg   <= out_next;
                m_en_reg    <= en_reg;
                m_viol_reg  <= run_reg & core_viol;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_lag_output       = m_lag_reg;
    assign m_enabled_out      = m_en_reg;
    assign m_timing_violation = m_viol_reg;

    `FOLI_ASSERT_NEXT(a_accept_closes, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after accept")
    `FOLI_ASSERT_IMPL(a_start_idle, aclk, aresetn, core_start, !core_stat.busy, "start while core busy")
    `FOLI_ASSERT_IMPL(a_done_owned, aclk, aresetn, core_stat.done, busy_reg && run_reg, "stray core result")
    `FOLI_ASSERT_IMPL(a_viol_enabled, aclk, aresetn, m_valid && m_timing_violation, m_enabled_out, "violation while disabled")

endmodule
